### src/mmbd_pkg.sv
package mmbd_pkg;

  // configuration register widths and the write port
  localparam int PC_W      = 21;
  localparam int PW_W      = 13;
  localparam int CFG_W     = 21;
  localparam int REG_IDX_W = 1;

  // results one item can cause at most
  localparam int SLOTS  = 3;
  localparam int SLOT_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_PIXEL_WIDTH = 1'b1
  } reg_idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic div_start;
    logic restart;
    logic accept;
    logic build;
    logic load;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_busy;
    logic slot_pending;
    logic slot_final;
    logic out_free;
  } dp_status_t;

endpackage

### src/mmbd_div.sv
module mmbd_div #(
  parameter int NB = 21,
  parameter int WB = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [WB-1:0] divisor,
  output logic          busy,
  output logic [NB-1:0] quotient,
  output logic [WB-1:0] remainder
);

  localparam int CNT_W = $clog2(NB + 1);

  logic [CNT_W-1:0] cnt;
  logic [NB-1:0]    dq;
  logic [WB-1:0]    rem;
  logic [WB-1:0]    div_r;
  logic [WB:0]      trial;
  logic [WB:0]      diff;
  logic             ge;
  logic [WB-1:0]    rem_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dq[NB-1]};
    ge       = trial >= {1'b0, div_r};
    diff     = trial - {1'b0, div_r};
    rem_next = ge ? diff[WB-1:0] : trial[WB-1:0];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NB);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // quotient shares the dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      rem   <= '0;
      div_r <= divisor;
    end else if (busy) begin
      dq  <= {dq[NB-2:0], ge};
      rem <= rem_next;
    end
  end

  assign busy      = cnt != '0;
  assign quotient  = dq;
  assign remainder = rem;

endmodule

### src/mmbd_dp.sv
module mmbd_dp #(
  parameter int INDEX_BITS = 20,
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mmbd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mmbd_pkg::CFG_W-1:0]    cfg_data,
  input  logic signed [VALUE_BITS-1:0]  cost_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [INDEX_BITS-1:0]         sample_index,
  output logic signed [VALUE_BITS-1:0]  sample_value,
  output logic                          run_last,
  output logic                          stream_done,
  input  mmbd_pkg::ctrl_cmd_t           cmd,
  output mmbd_pkg::dp_status_t          st
);

  import mmbd_pkg::*;

  localparam int NB  = INDEX_BITS + 1;
  localparam int WB  = WIDTH_BITS + 1;
  localparam int ENW = (NB > PC_W) ? NB : PC_W;
  localparam int EWW = (WB > PW_W) ? WB : PW_W;
  localparam int CB  = ((NB > WB) ? NB : WB) + 1;

  // configuration registers
  logic [PC_W-1:0] points_cfg;
  logic [PW_W-1:0] width_cfg;

  // effective sizes
  logic [ENW-1:0] pc_ext;
  logic [ENW-1:0] n_cap;
  logic [EWW-1:0] pw_ext;
  logic [EWW-1:0] w_cap;
  logic [NB-1:0]  eff_n;
  logic [WB-1:0]  eff_w;
  logic [WB-1:0]  eff_b;
  logic [CB-1:0]  n_c;
  logic [CB-1:0]  w_c;
  logic           eff_pass;

  logic [WB-1:0]         b_r;
  logic                  pass_r;
  logic [INDEX_BITS-1:0] last_r;

  // divider results: first bucket end and its remainder
  logic          div_busy;
  logic [NB-1:0] quot;
  logic [WB-1:0] qrem;

  // stream state
  logic [INDEX_BITS-1:0]        counter;
  logic [NB-1:0]                bend;
  logic [WB-1:0]                brem;
  logic                         fresh;
  logic signed [VALUE_BITS-1:0] min_val;
  logic [INDEX_BITS-1:0]        min_idx;
  logic signed [VALUE_BITS-1:0] max_val;
  logic [INDEX_BITS-1:0]        max_idx;
  logic [INDEX_BITS-1:0]        prev_idx;
  logic                         prev_valid;

  // current item
  logic signed [VALUE_BITS-1:0] cur_val;
  logic [INDEX_BITS-1:0]        cur_idx;
  logic                         is_zero;
  logic                         is_end;
  logic                         is_last;

  logic          at_end;
  logic          at_last;
  logic [WB:0]   rsum;
  logic          carry;
  logic [WB-1:0] brem_next;
  logic [NB-1:0] bend_next;

  // result slots
  logic [INDEX_BITS-1:0]        slot_idx [SLOTS];
  logic signed [VALUE_BITS-1:0] slot_val [SLOTS];
  logic                         slot_done [SLOTS];
  logic [SLOT_W-1:0]            cnt;
  logic [SLOT_W-1:0]            ptr;

  // build results
  logic [INDEX_BITS-1:0]        bld_idx [SLOTS];
  logic signed [VALUE_BITS-1:0] bld_val [SLOTS];
  logic [SLOT_W:0]              bld_k;
  logic [INDEX_BITS-1:0]        bld_prev_idx;
  logic                         bld_prev_valid;
  logic                         cand_en  [4];
  logic [INDEX_BITS-1:0]        cand_idx [4];
  logic signed [VALUE_BITS-1:0] cand_val [4];
  logic                         min_first;

  // clamp the registers and take the bucket count
  always_comb begin
    pc_ext = ENW'(points_cfg);
    n_cap  = ENW'(1) << INDEX_BITS;
    pw_ext = EWW'(width_cfg);
    w_cap  = EWW'(1) << WIDTH_BITS;
    if (points_cfg == '0) begin
      eff_n = NB'(1);
    end else if (pc_ext > n_cap) begin
      eff_n = NB'(n_cap);
    end else begin
      eff_n = NB'(pc_ext);
    end
    if (width_cfg == '0) begin
      eff_w = WB'(1);
    end else if (pw_ext > w_cap) begin
      eff_w = WB'(w_cap);
    end else begin
      eff_w = WB'(pw_ext);
    end
    n_c      = CB'(eff_n);
    w_c      = CB'(eff_w);
    eff_b    = (n_c < w_c) ? WB'(n_c) : eff_w;
    eff_pass = n_c <= (CB'(eff_b) << 1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      points_cfg <= PC_W'(1);
      width_cfg  <= PW_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POINT_COUNT: points_cfg <= cfg_data[PC_W-1:0];
        REG_PIXEL_WIDTH: width_cfg  <= cfg_data[PW_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes held for the stream
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      b_r    <= eff_b;
      pass_r <= eff_pass;
      last_r <= INDEX_BITS'(eff_n - NB'(1));
    end
  end

  mmbd_div #(
    .NB(NB),
    .WB(WB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (eff_n),
    .divisor  (eff_b),
    .busy     (div_busy),
    .quotient (quot),
    .remainder(qrem)
  );

  // bucket end stepping: end grows by quotient, plus one when the remainder wraps
  always_comb begin
    at_end    = (NB'(counter) + NB'(1)) == bend;
    at_last   = counter == last_r;
    rsum      = {1'b0, brem} + {1'b0, qrem};
    carry     = rsum >= {1'b0, b_r};
    brem_next = carry ? WB'(rsum - {1'b0, b_r}) : WB'(rsum);
    bend_next = bend + quot + NB'(carry);
  end

  // stream control state
  always_ff @(posedge clk) begin
    if (rst) begin
      counter    <= '0;
      fresh      <= 1'b1;
      prev_valid <= 1'b0;
    end else if (cmd.restart) begin
      counter    <= '0;
      fresh      <= 1'b1;
      prev_valid <= 1'b0;
    end else if (cmd.accept) begin
      if (at_last) begin
        counter <= '0;
        fresh   <= 1'b1;
      end else begin
        counter <= counter + INDEX_BITS'(1);
        fresh   <= at_end;
      end
    end else if (cmd.build) begin
      prev_valid <= is_last ? 1'b0 : bld_prev_valid;
    end
  end

  // bucket bounds and running extremes
  always_ff @(posedge clk) begin
    if (cmd.restart || (cmd.accept && at_last)) begin
      bend <= quot;
      brem <= qrem;
    end else if (cmd.accept && at_end) begin
      bend <= bend_next;
      brem <= brem_next;
    end
    if (cmd.accept) begin
      cur_val <= cost_in;
      cur_idx <= counter;
      is_zero <= counter == '0;
      is_end  <= at_end;
      is_last <= at_last;
      if (fresh || (cost_in < min_val)) begin
        min_val <= cost_in;
        min_idx <= counter;
      end
      if (fresh || (cost_in > max_val)) begin
        max_val <= cost_in;
        max_idx <= counter;
      end
    end
  end

  // candidates in emission order, repeats of the previous index dropped
  always_comb begin
    min_first   = min_idx < max_idx;
    cand_en[0]  = pass_r || is_zero;
    cand_idx[0] = cur_idx;
    cand_val[0] = cur_val;
    cand_en[1]  = !pass_r && is_end;
    cand_idx[1] = min_first ? min_idx : max_idx;
    cand_val[1] = min_first ? min_val : max_val;
    cand_en[2]  = !pass_r && is_end;
    cand_idx[2] = min_first ? max_idx : min_idx;
    cand_val[2] = min_first ? max_val : min_val;
    cand_en[3]  = !pass_r && is_last;
    cand_idx[3] = cur_idx;
    cand_val[3] = cur_val;
    bld_k          = '0;
    bld_prev_idx   = prev_idx;
    bld_prev_valid = prev_valid;
    for (int i = 0; i < SLOTS; i++) begin
      bld_idx[i] = cur_idx;
      bld_val[i] = cur_val;
    end
    for (int j = 0; j < 4; j++) begin
      if (cand_en[j] && !(bld_prev_valid && (bld_prev_idx == cand_idx[j]))) begin
        if (bld_k < (SLOT_W + 1)'(SLOTS)) begin
          bld_idx[bld_k[SLOT_W-1:0]] = cand_idx[j];
          bld_val[bld_k[SLOT_W-1:0]] = cand_val[j];
          bld_k = bld_k + (SLOT_W + 1)'(1);
        end
        bld_prev_idx   = cand_idx[j];
        bld_prev_valid = 1'b1;
      end
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (cmd.build) begin
      prev_idx <= bld_prev_idx;
      for (int i = 0; i < SLOTS; i++) begin
        slot_idx[i]  <= bld_idx[i];
        slot_val[i]  <= bld_val[i];
        slot_done[i] <= bld_idx[i] == last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (cmd.build) begin
      cnt <= bld_k[SLOT_W-1:0];
      ptr <= '0;
    end else if (cmd.load) begin
      ptr <= ptr + SLOT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_index <= slot_idx[ptr];
      sample_value <= slot_val[ptr];
      stream_done  <= slot_done[ptr];
      run_last     <= st.slot_final;
    end
  end

  assign st.div_busy     = div_busy;
  assign st.slot_pending = ptr < cnt;
  assign st.slot_final   = ptr == (cnt - SLOT_W'(1));
  assign st.out_free     = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  // a result is only moved out while the slots still hold one
  assert property (@(posedge clk) disable iff (rst) cmd.load |-> (ptr < cnt))
    else $error("result loaded from an empty slot");

  // an accepted item never lies past the end of its bucket
  assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (NB'(counter) < bend))
    else $error("sample index beyond bucket end");

  // no item causes more results than the slots hold
  assert property (@(posedge clk) disable iff (rst)
    cmd.build |=> (cnt <= SLOT_W'(SLOTS)))
    else $error("result count overflow");
`endif

endmodule

### src/mmbd_ctrl.sv
module mmbd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mmbd_pkg::dp_status_t st,
  output mmbd_pkg::ctrl_cmd_t  cmd
);

  import mmbd_pkg::*;

  typedef enum logic [2:0] {
    S_START,
    S_DIV,
    S_IDLE,
    S_BUILD,
    S_EMIT
  } state_t;

  state_t state;
  logic   ready;

  // sequencer: divide after reset or a write, then take one item at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
      ready <= 1'b0;
    end else if (cfg_we) begin
      state <= S_START;
      ready <= 1'b0;
    end else begin
      unique case (state)
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!st.div_busy) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && ready) begin
            state <= S_BUILD;
            ready <= 1'b0;
          end
        end
        S_BUILD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!st.slot_pending || (st.out_free && st.slot_final)) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_START;
          ready <= 1'b0;
        end
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd.div_start = state == S_START;
    cmd.restart   = (state == S_DIV) && !st.div_busy;
    cmd.accept    = in_valid && ready;
    cmd.build     = state == S_BUILD;
    cmd.load      = (state == S_EMIT) && st.slot_pending && st.out_free;
  end

  assign in_ready = ready;

`ifndef NO_ASSERTIONS
  // results are built in the cycle after an item is taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.build |-> $past(in_valid && ready))
    else $error("build without an accepted item");

  // no item is taken while the bucket division runs
  assert property (@(posedge clk) disable iff (rst) ready |-> !st.div_busy)
    else $error("ready while divider busy");
`endif

endmodule

### src/min_max_bucket_decimator_unit.sv
// Min/max decimator for plotting a history of cost samples. Write the point count
// (index 0) and the pixel width (index 1), then stream the samples on cost_in; the
// block passes every sample when the history is short, and otherwise sends
// sample 0, the minimum and maximum of each bucket in index order, and the final
// sample, with repeated indices dropped. Every register write, and reset, starts
// a fresh history and runs a bit-serial division for the bucket size: items are
// refused until it ends. Each item is then taken and sorted into result slots, and
// the controller steps through the result slots one per cycle while the output
// register is free or being emptied; the output register lets the next item in
// while the last result waits to be taken. run_last marks the last result of an
// item and stream_done the result of the final history point.
module min_max_bucket_decimator_unit #(
  parameter int INDEX_BITS = 20,
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mmbd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mmbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [VALUE_BITS-1:0]   cost_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [INDEX_BITS-1:0]          sample_index,
  output logic signed [VALUE_BITS-1:0]   sample_value,
  output logic                           run_last,
  output logic                           stream_done
);

  import mmbd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  mmbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  mmbd_dp #(
    .INDEX_BITS(INDEX_BITS),
    .VALUE_BITS(VALUE_BITS),
    .WIDTH_BITS(WIDTH_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cost_in     (cost_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_index(sample_index),
    .sample_value(sample_value),
    .run_last    (run_last),
    .stream_done (stream_done),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

### verif/tb_min_max_bucket_decimator_unit.sv
module tb_min_max_bucket_decimator_unit;
  import mmbd_pkg::*;

  localparam int INDEX_BITS = 20;
  localparam int VALUE_BITS = 32;
  localparam int WIDTH_BITS = 12;
  localparam longint unsigned POINT_CAP = 64'd1 << INDEX_BITS;
  localparam longint unsigned WIDTH_CAP = 64'd1 << WIDTH_BITS;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT = 4000;
  // directed items make up the rest of the run
  localparam int RANDOM_ITEMS = 305;

  // one kept sample as the block sends it
  typedef struct {
    logic [INDEX_BITS-1:0]        index;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
    logic                         done;
  } kept_sample_t;

  // decimation predictor and the queue of kept samples still owed
  class decimation_scoreboard;
    kept_sample_t kept_q[$];
    kept_sample_t step_q[$];
    int errors;
    logic [PC_W-1:0] point_reg;
    logic [PW_W-1:0] width_reg;
    longint unsigned sample_no;
    longint unsigned bucket_no;
    longint unsigned bucket_end;
    longint unsigned min_at;
    longint unsigned max_at;
    longint unsigned prev_index;
    logic signed [VALUE_BITS-1:0] min_val;
    logic signed [VALUE_BITS-1:0] max_val;
    bit have_prev;
    bit bucket_open;

    function new();
      errors = 0;
      point_reg = 1;
      width_reg = 1;
      restart();
    endfunction

    function longint unsigned points();
      if (point_reg == 0) return 1;
      if (point_reg > POINT_CAP) return POINT_CAP;
      return point_reg;
    endfunction

    function longint unsigned buckets();
      longint unsigned w;
      longint unsigned n;
      w = width_reg;
      n = points();
      if (w == 0) w = 1;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      return (n < w) ? n : w;
    endfunction

    // fresh history, as after reset
    function void restart();
      sample_no = 0;
      bucket_no = 0;
      bucket_end = points() / buckets();
      min_val = 0;
      min_at = 0;
      max_val = 0;
      max_at = 0;
      prev_index = 0;
      have_prev = 0;
      bucket_open = 1;
    endfunction

    function void set_register(reg_idx_t r, logic [CFG_W-1:0] d);
      case (r)
        REG_POINT_COUNT: point_reg = d[PC_W-1:0];
        REG_PIXEL_WIDTH: width_reg = d[PW_W-1:0];
        default: ;
      endcase
      restart();
    endfunction

    // repeated index is dropped
    function void keep(longint unsigned idx, logic signed [VALUE_BITS-1:0] val);
      kept_sample_t s;
      if (have_prev && prev_index == idx) return;
      prev_index = idx;
      have_prev = 1;
      s.index = idx[INDEX_BITS-1:0];
      s.value = val;
      s.last = 1'b0;
      s.done = (idx == points() - 1);
      step_q = {step_q, s};
    endfunction

    function void note_cost(logic signed [VALUE_BITS-1:0] v);
      longint unsigned n;
      longint unsigned b;
      longint unsigned idx;
      bit closing;
      n = points();
      b = buckets();
      idx = sample_no;
      closing = (idx == n - 1);
      step_q.delete();
      if (n <= 2 * b) begin
        keep(idx, v);
      end else begin
        if (idx == 0) keep(idx, v);
        if (bucket_open) begin
          min_val = v;
          min_at = idx;
          max_val = v;
          max_at = idx;
          bucket_open = 0;
        end else begin
          // strict compares so ties keep the earliest index
          if (v < min_val) begin
            min_val = v;
            min_at = idx;
          end
          if (v > max_val) begin
            max_val = v;
            max_at = idx;
          end
        end
        // bucket closes: min and max in index order
        if (idx + 1 == bucket_end) begin
          if (min_at < max_at) begin
            keep(min_at, min_val);
            keep(max_at, max_val);
          end else begin
            keep(max_at, max_val);
            keep(min_at, min_val);
          end
          bucket_no = (bucket_no + 1) & (WIDTH_CAP - 1);
          bucket_end = ((bucket_no + 1) * n) / b;
          bucket_open = 1;
        end
        if (closing) keep(idx, v);
      end
      foreach (step_q[i]) begin
        step_q[i].last = (i == step_q.size() - 1);
        kept_q = {kept_q, step_q[i]};
      end
      if (closing) restart();
      else sample_no = (idx + 1) & (POINT_CAP - 1);
    endfunction

    function void check_kept(logic [INDEX_BITS-1:0] idx, logic signed [VALUE_BITS-1:0] val,
                             logic last, logic done);
      kept_sample_t e;
      if (kept_q.size() == 0) begin
        $error("unexpected item: sample_index %0d sample_value %0d", idx, val);
        errors++;
        return;
      end
      e = kept_q.pop_front();
      if (idx !== e.index) begin
        $error("sample_index: expected %0d, got %0d", e.index, idx);
        errors++;
      end
      if (val !== e.value) begin
        $error("sample_value: expected %0d, got %0d", e.value, val);
        errors++;
      end
      if (last !== e.last) begin
        $error("run_last: expected %0b, got %0b", e.last, last);
        errors++;
      end
      if (done !== e.done) begin
        $error("stream_done: expected %0b, got %0b", e.done, done);
        errors++;
      end
    endfunction

    function int pending();
      return kept_q.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]         cfg_index = REG_POINT_COUNT;
  logic [CFG_W-1:0]             cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] cost_in = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [INDEX_BITS-1:0]        sample_index;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         run_last;
  logic                         stream_done;

  decimation_scoreboard sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int random_items = 0;
  logic signed [VALUE_BITS-1:0] prev_cost = '0;

  min_max_bucket_decimator_unit #(
    .INDEX_BITS(INDEX_BITS),
    .VALUE_BITS(VALUE_BITS),
    .WIDTH_BITS(WIDTH_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cost_in(cost_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_index(sample_index),
    .sample_value(sample_value),
    .run_last(run_last),
    .stream_done(stream_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls: always ready, coin toss, or mostly stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_kept(sample_index, sample_value, run_last, stream_done);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // sender in bursts with gaps between them
  task automatic send_cost(input logic signed [VALUE_BITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    cost_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_cost(v);
    prev_cost = v;
  endtask

  task automatic stop_sending();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // wait for all owed items, then for the block to finish silent work
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t r, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(negedge clk) cfg_we <= 1'b0;
    sb.set_register(r, d);
  endtask

  // extremes, ties and repeats of the previous value
  function automatic logic signed [VALUE_BITS-1:0] random_cost();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 15)) - 8;
      4: return prev_cost;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic feed_random(input int count);
    repeat (count) begin
      send_cost(random_cost());
      random_items++;
    end
    stop_sending();
  endtask

  initial begin
    int phase;
    int pc_pick;
    int pw_pick;
    int count;
    longint unsigned n;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // one point, one pixel: every item passes through and ends the history
    send_cost(32'sh7FFFFFFF);
    send_cost(32'sh80000000);
    send_cost(32'sh0);
    stop_sending();
    drain();

    // zero registers act as one
    write_register(REG_POINT_COUNT, 21'd0);
    write_register(REG_PIXEL_WIDTH, 21'd0);
    send_cost(-32'sd1);
    send_cost(32'sd1);
    stop_sending();
    drain();

    // two buckets: sample 0 and the final sample repeat a bucket index
    write_register(REG_POINT_COUNT, 21'd6);
    write_register(REG_PIXEL_WIDTH, 21'd2);
    send_cost(-32'sd5);
    send_cost(32'sd3);
    send_cost(32'sd10);
    send_cost(32'sd4);
    send_cost(-32'sd1);
    send_cost(32'sd20);
    stop_sending();
    drain();

    // extremes with ties, then a flat bucket whose min and max coincide
    write_register(REG_POINT_COUNT, 21'd12);
    send_cost(32'sd5);
    send_cost(32'sh80000000);
    send_cost(32'sh7FFFFFFF);
    send_cost(32'sh80000000);
    send_cost(32'sh0);
    send_cost(32'sh7FFFFFFF);
    repeat (6) send_cost(32'sd7);
    stop_sending();
    drain();

    // point count exactly twice the buckets still passes through
    write_register(REG_POINT_COUNT, 21'd10);
    write_register(REG_PIXEL_WIDTH, 21'd5);
    send_cost(32'sd100);
    send_cost(-32'sd100);
    stop_sending();
    drain();

    // random phases, the first few on saturating register values
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          write_register(REG_POINT_COUNT, 21'h1FFFFF);
          write_register(REG_PIXEL_WIDTH, 21'h001FFF);
          count = 20;
        end
        1: begin
          write_register(REG_POINT_COUNT, 21'd10000);
          count = 40;
        end
        2: begin
          write_register(REG_PIXEL_WIDTH, 21'h001000);
          write_register(REG_POINT_COUNT, 21'd8193);
          count = 30;
        end
        3: begin
          write_register(REG_POINT_COUNT, 21'h100000);
          count = 12;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: pc_pick = $urandom_range(0, 3);
            7, 8: pc_pick = $urandom_range(41, 120);
            9: pc_pick = $urandom_range(121, 21'h1FFFFF);
            default: pc_pick = $urandom_range(4, 40);
          endcase
          case ($urandom_range(0, 9))
            0: pw_pick = $urandom_range(0, 1);
            8: pw_pick = $urandom_range(13, 200);
            9: pw_pick = $urandom_range(0, 21'h1FFFFF);
            default: pw_pick = $urandom_range(2, 12);
          endcase
          case ($urandom_range(0, 7))
            0: ;
            1: write_register(REG_POINT_COUNT, pc_pick[CFG_W-1:0]);
            2: write_register(REG_PIXEL_WIDTH, pw_pick[CFG_W-1:0]);
            3, 4: begin
              write_register(REG_PIXEL_WIDTH, pw_pick[CFG_W-1:0]);
              write_register(REG_POINT_COUNT, pc_pick[CFG_W-1:0]);
            end
            default: begin
              write_register(REG_POINT_COUNT, pc_pick[CFG_W-1:0]);
              write_register(REG_PIXEL_WIDTH, pw_pick[CFG_W-1:0]);
            end
          endcase
          // whole histories plus a broken tail, or a slice of a long one
          n = sb.points();
          if (n <= 150) count = int'(n) * $urandom_range(1, 3) + $urandom_range(0, 2);
          else count = $urandom_range(10, 60);
        end
      endcase
      // last phase trimmed to the item budget
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      feed_random(count);
      drain();
      phase++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
